### sv/hsv_to_rgb_convert_defines.svh
// ----------------------------------------------------------------------------
// HSV to RGB converter assertion macros
// Shared helpers for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERT_DEFINES_SVH
`define HSV_TO_RGB_CONVERT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HSV2RGB_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HSV2RGB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/hsv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Payload types, sector codes and fixed-point constants for the converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  typedef struct packed {
    logic signed [15:0] hue_degrees;
    logic signed [15:0] saturation;
    logic signed [15:0] brightness;
  } hsv_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_out_t;

  // Finished result leaving the arithmetic pipeline.
  typedef struct packed {
    logic     valid;
    rgb_out_t data;
  } pipe_out_t;

  typedef enum logic [2:0] {
    SECT_0 = 3'd0,
    SECT_1 = 3'd1,
    SECT_2 = 3'd2,
    SECT_3 = 3'd3,
    SECT_4 = 3'd4,
    SECT_5 = 3'd5
  } sector_t;

  // Channel term indices.
  localparam int unsigned TERM_V = 0;
  localparam int unsigned TERM_P = 1;
  localparam int unsigned TERM_Q = 2;
  localparam int unsigned TERM_T = 3;
  localparam int unsigned NUM_TERMS = 4;

  localparam logic [14:0] UNIT_ONE   = 15'd16384;     // 1.0 in Q2.14
  localparam logic [19:0] BIG_ONE    = 20'd983040;    // 60 * 1.0
  localparam logic [16:0] HUE_OFFSET = 17'd65520;     // 182 * 360
  localparam logic [14:0] RECIP_45   = 15'd23302;     // ceil(2^20 / 45)
  localparam logic [12:0] RECIP_15   = 13'd4370;      // ceil(2^16 / 15)
  localparam logic [5:0]  DEG_SECTOR = 6'd60;

endpackage

### sv/hsv2rgb_core.sv
// ----------------------------------------------------------------------------
// HSV to RGB arithmetic pipeline
// Six register stages: hue wrap, sector split, term setup, brightness
// multiply, scale by 255, divide by 15 and route to the colour channels.
// ----------------------------------------------------------------------------
module hsv2rgb_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  hsv_valid,
  input  hsv2rgb_pkg::hsv_in_t  hsv,
  output hsv2rgb_pkg::pipe_out_t pipe
);
  import hsv2rgb_pkg::*;

  logic [5:0] vld;

  // Stage 1: clamped inputs and the quotient estimate for the hue wrap.
  logic [16:0] hue_ofs;
  logic [14:0] sat_clamp;
  logic [14:0] val_clamp;
  logic [13:0] s1_w;
  logic [2:0]  s1_lo;
  logic [28:0] s1_prod;
  logic [14:0] s1_sat;
  logic [14:0] s1_val;

  // Stage 2: wrapped hue split into sector and remainder.
  logic [8:0]  s1_q;
  logic [13:0] s1_r45;
  logic [8:0]  hue_wrap;
  logic [8:0]  sect_base;
  sector_t     sect_comb;
  sector_t     s2_sector;
  logic [5:0]  s2_rem;
  logic [14:0] s2_sat;
  logic [14:0] s2_val;

  // Stage 3: one minus saturation times the sector fraction, per term.
  logic [5:0]  k_t;
  logic [20:0] sk_p;
  logic [20:0] sk_q;
  logic [20:0] sk_t;
  logic [19:0] s3_inner [NUM_TERMS];
  sector_t     s3_sector;
  logic [14:0] s3_val;

  // Stage 4: brightness products.
  logic [33:0] s4_m [NUM_TERMS];
  sector_t     s4_sector;

  // Stage 5: scaled by 255 and reduced by 2^30.
  logic [41:0] scaled [NUM_TERMS];
  logic [11:0] s5_z [NUM_TERMS];
  sector_t     s5_sector;

  // Stage 6: divided by 15 and routed.
  logic [24:0] div_prod [NUM_TERMS];
  logic [7:0]  term [NUM_TERMS];
  rgb_out_t    rgb_comb;
  rgb_out_t    s6_rgb;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[4:0], hsv_valid};
    end
  end

  // ---------------- stage 1 ----------------
  always_comb begin
    hue_ofs = 17'({hsv.hue_degrees[15], hsv.hue_degrees}) + HUE_OFFSET;
    if (hsv.saturation[15]) begin
      sat_clamp = '0;
    end else if (hsv.saturation[14:0] > UNIT_ONE) begin
      sat_clamp = UNIT_ONE;
    end else begin
      sat_clamp = hsv.saturation[14:0];
    end
    if (hsv.brightness[15]) begin
      val_clamp = '0;
    end else if (hsv.brightness[14:0] > UNIT_ONE) begin
      val_clamp = UNIT_ONE;
    end else begin
      val_clamp = hsv.brightness[14:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_w    <= hue_ofs[16:3];
      s1_lo   <= hue_ofs[2:0];
      s1_prod <= 29'(hue_ofs[16:3]) * 29'(RECIP_45);
      s1_sat  <= sat_clamp;
      s1_val  <= val_clamp;
    end
  end

  // ---------------- stage 2 ----------------
  // The hue is wrapped as ((h >> 3) mod 45) * 8 + (h & 7), which is h mod 360.
  always_comb begin
    s1_q     = s1_prod[28:20];
    s1_r45   = s1_w - 14'(s1_q) * 14'(6'd45);
    hue_wrap = {s1_r45[5:0], s1_lo};
    if (hue_wrap >= 9'd300) begin
      sect_comb = SECT_5;
      sect_base = 9'd300;
    end else if (hue_wrap >= 9'd240) begin
      sect_comb = SECT_4;
      sect_base = 9'd240;
    end else if (hue_wrap >= 9'd180) begin
      sect_comb = SECT_3;
      sect_base = 9'd180;
    end else if (hue_wrap >= 9'd120) begin
      sect_comb = SECT_2;
      sect_base = 9'd120;
    end else if (hue_wrap >= 9'd60) begin
      sect_comb = SECT_1;
      sect_base = 9'd60;
    end else begin
      sect_comb = SECT_0;
      sect_base = 9'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_sector <= sect_comb;
      s2_rem    <= 6'(hue_wrap - sect_base);
      s2_sat    <= s1_sat;
      s2_val    <= s1_val;
    end
  end

  // ---------------- stage 3 ----------------
  always_comb begin
    k_t  = DEG_SECTOR - s2_rem;
    sk_p = 21'(s2_sat) * 21'(DEG_SECTOR);
    sk_q = 21'(s2_sat) * 21'(s2_rem);
    sk_t = 21'(s2_sat) * 21'(k_t);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_inner[TERM_V] <= BIG_ONE;
      s3_inner[TERM_P] <= 20'(21'(BIG_ONE) - sk_p);
      s3_inner[TERM_Q] <= 20'(21'(BIG_ONE) - sk_q);
      s3_inner[TERM_T] <= 20'(21'(BIG_ONE) - sk_t);
      s3_sector        <= s2_sector;
      s3_val           <= s2_val;
    end
  end

  // ---------------- stage 4 ----------------
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_TERMS; i++) begin
        s4_m[i] <= 34'(s3_val) * 34'(s3_inner[i]);
      end
      s4_sector <= s3_sector;
    end
  end

  // ---------------- stage 5 ----------------
  // Channel is floor(m * 255 / (15 * 2^30)); the 2^30 part is taken here.
  always_comb begin
    for (int i = 0; i < NUM_TERMS; i++) begin
      scaled[i] = {s4_m[i], 8'b0} - {8'b0, s4_m[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_TERMS; i++) begin
        s5_z[i] <= scaled[i][41:30];
      end
      s5_sector <= s4_sector;
    end
  end

  // ---------------- stage 6 ----------------
  // The reciprocal of 15 is exact for every value below 4096.
  always_comb begin
    for (int i = 0; i < NUM_TERMS; i++) begin
      div_prod[i] = 25'(s5_z[i]) * 25'(RECIP_15);
      term[i]     = div_prod[i][23:16];
    end
    case (s5_sector)
      SECT_1: begin
        rgb_comb = '{red: term[TERM_Q], green: term[TERM_V], blue: term[TERM_P]};
      end
      SECT_2: begin
        rgb_comb = '{red: term[TERM_P], green: term[TERM_V], blue: term[TERM_T]};
      end
      SECT_3: begin
        rgb_comb = '{red: term[TERM_P], green: term[TERM_Q], blue: term[TERM_V]};
      end
      SECT_4: begin
        rgb_comb = '{red: term[TERM_T], green: term[TERM_P], blue: term[TERM_V]};
      end
      SECT_5: begin
        rgb_comb = '{red: term[TERM_V], green: term[TERM_P], blue: term[TERM_Q]};
      end
      default: begin
        rgb_comb = '{red: term[TERM_V], green: term[TERM_T], blue: term[TERM_P]};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_rgb <= rgb_comb;
    end
  end

  assign pipe = '{valid: vld[5], data: s6_rgb};

endmodule

### sv/hsv2rgb_skid.sv
// ----------------------------------------------------------------------------
// HSV to RGB output skid buffer
// Two-entry output stage; its ready is registered so that the receiver's
// ready never reaches the pipeline combinationally.
// ----------------------------------------------------------------------------
module hsv2rgb_skid (
  input  logic                   clk,
  input  logic                   rst,
  input  hsv2rgb_pkg::pipe_out_t pipe,
  output logic                   ready,
  output logic                   rgb_valid,
  input  logic                   rgb_ready,
  output hsv2rgb_pkg::rgb_out_t  rgb
);
  import hsv2rgb_pkg::*;

  logic     spare_valid;
  rgb_out_t spare;
  logic     take;
  logic     drain;

  assign ready = !spare_valid;
  assign take  = pipe.valid && !spare_valid;
  assign drain = rgb_ready || !rgb_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      rgb_valid   <= 1'b0;
      spare_valid <= 1'b0;
    end else if (drain) begin
      if (spare_valid) begin
        rgb_valid   <= 1'b1;
        spare_valid <= 1'b0;
      end else begin
        rgb_valid <= take;
      end
    end else if (take) begin
      spare_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      if (spare_valid) begin
        rgb <= spare;
      end else if (take) begin
        rgb <= pipe.data;
      end
    end else if (take) begin
      spare <= pipe.data;
    end
  end

endmodule

### sv/hsv_to_rgb_convert.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Converts one HSV colour per transaction to 8-bit red, green and blue.
// ----------------------------------------------------------------------------
// Usage:
//   The hsv channel (hsv_valid / hsv_ready / hsv) carries hue in degrees,
//   wrapped modulo 360, and saturation and brightness in Q2.14, clamped to
//   0..1.0. The rgb channel (rgb_valid / rgb_ready / rgb) returns one result
//   per input transaction, in order.
//   A transaction passes the six arithmetic stages and then the output
//   register before it can be taken at the rgb side. The longest path in
//   a stage is one multiply, at times chained with an add, subtract,
//   compare or mux, or one wide subtraction.
//   Throughput is one transaction per cycle for as long as the receiver
//   keeps rgb_ready high.
//   When the receiver stalls, the output buffer holds the waiting result
//   and catches one more; hsv_ready then drops and the whole pipeline
//   freezes in place, so nothing is lost or repeated. hsv_ready is driven
//   from a register and does not depend on rgb_ready in the same cycle.
//   Synchronous reset empties the pipeline and the buffer; the block holds
//   no other state, and hsv_ready is high from the first cycle after reset.
// ----------------------------------------------------------------------------
`include "hsv_to_rgb_convert_defines.svh"

module hsv_to_rgb_convert (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  hsv_valid,
  output logic                  hsv_ready,
  input  hsv2rgb_pkg::hsv_in_t  hsv,
  output logic                  rgb_valid,
  input  logic                  rgb_ready,
  output hsv2rgb_pkg::rgb_out_t rgb
);
  import hsv2rgb_pkg::*;

  pipe_out_t pipe;
  logic      advance;

  hsv2rgb_core u_core (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .hsv_valid (hsv_valid),
    .hsv       (hsv),
    .pipe      (pipe)
  );

  hsv2rgb_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .pipe      (pipe),
    .ready     (advance),
    .rgb_valid (rgb_valid),
    .rgb_ready (rgb_ready),
    .rgb       (rgb)
  );

  assign hsv_ready = advance;

  // Backpressure only appears when the output already holds a result.
  `HSV2RGB_ASSERT_SAME(a_stall_has_output, clk, rst, !hsv_ready, rgb_valid,
    "input stalled with no result waiting at the output")

  // Ready may only fall after the receiver refused a waiting result.
  `HSV2RGB_ASSERT_SAME(a_stall_cause, clk, rst, $fell(hsv_ready),
    $past(rgb_valid && !rgb_ready), "input stalled without an output stall")

  // Once the receiver takes the waiting result, the pipeline restarts.
  `HSV2RGB_ASSERT_NEXT(a_stall_release, clk, rst,
    !hsv_ready && rgb_valid && rgb_ready, hsv_ready && rgb_valid,
    "pipeline did not restart after the output drained")

endmodule
